// ----- hw/rtl/bma_pkg.sv -----
// Shared request codes for the buddy memory allocator.
package bma_pkg;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

endpackage

// ----- hw/rtl/bma_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module bma_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 11264
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/buddy_memory_allocator.sv -----
// Buddy memory allocator: free-list sequencer around one block-start RAM.
//
//   channel | direction | fields
//   req_    | in        | mode, request_size, block_start, block_level
//   rsp_    | out       | ok, granted_start, granted_level
//
// One request is handled at a time; req_ready is high only while idle.
// An allocate rounds the size up one level at a time, scans the levels for a free block,
// removes the head entry by moving the later entries down, then splits; a free searches
// its level's list for the buddy and, at each merged level, moves entries to remove it.
// All free lists share the single RAM port pair, so these steps run one after another.
// Reset is synchronous; the top level then holds the whole pool at start zero.
// A finished response waits in the output register until rsp_ready.
module buddy_memory_allocator #(
   parameter int POOL_LEVELS = 11,
   parameter int POOL_SIZE   = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [$clog2(POOL_SIZE):0]       req_request_size,
   input  logic [$clog2(POOL_SIZE)-1:0]     req_block_start,
   input  logic [$clog2(POOL_LEVELS)-1:0]   req_block_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic [$clog2(POOL_SIZE)-1:0]     rsp_granted_start,
   output logic [$clog2(POOL_LEVELS)-1:0]   rsp_granted_level
);

   localparam int ADDR_W = $clog2(POOL_SIZE);
   localparam int SZ_W   = ADDR_W + 1;
   localparam int LVL_W  = $clog2(POOL_LEVELS);
   localparam int CNT_W  = $clog2(POOL_SIZE + 1);
   localparam int DEPTH  = POOL_LEVELS * POOL_SIZE;
   localparam int RA_W   = $clog2(DEPTH);
   localparam logic [LVL_W-1:0] TOP = LVL_W'(POOL_LEVELS - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(POOL_SIZE);

   typedef enum logic [3:0] {
      S_IDLE, S_A_LOG, S_A_FIND, S_A_HEAD, S_A_SPLIT, S_A_APP,
      S_RM, S_RM_WR, S_F_CHK, S_F_SRCH, S_F_CMP, S_F_MERGE, S_F_APP, S_DONE
   } state_type;

   state_type               state_ff, state_in, ret_ff, ret_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in, p_ff, p_in;
   logic [ADDR_W-1:0]       s_ff, s_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [SZ_W-1:0]         size_ff, size_in;
   logic [CNT_W-1:0]        cnt_ff [POOL_LEVELS];
   logic                    cnt_inc, cnt_dec;
   logic                    topz_ff, topz_in, virt_ff, virt_in;
   logic                    res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]       res_s_ff, res_s_in;
   logic [LVL_W-1:0]        res_l_ff, res_l_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]       rsp_s_ff, rsp_s_in;
   logic [LVL_W-1:0]        rsp_l_ff, rsp_l_in;

   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_pos, rd_pos, wr_data, ram_q, rd_val;
   logic [RA_W-1:0]         wr_addr, rd_addr;
   logic [CNT_W-1:0]        cur_cnt;
   logic [ADDR_W-1:0]       lvl_bit;

   assign cur_cnt = cnt_ff[lvl_ff];
   assign lvl_bit = ADDR_W'(1) << lvl_ff;
   assign wr_addr = RA_W'({lvl_ff, wr_pos});
   assign rd_addr = RA_W'({lvl_ff, rd_pos});
   assign rd_val  = virt_ff ? '0 : ram_q;

   bma_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      lvl_in       = lvl_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      size_in      = size_ff;
      res_ok_in    = res_ok_ff;
      res_s_in     = res_s_ff;
      res_l_in     = res_l_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_s_in     = rsp_s_ff;
      rsp_l_in     = rsp_l_ff;
      cnt_inc      = 1'b0;
      cnt_dec      = 1'b0;
      wr_en        = 1'b0;
      wr_pos       = ADDR_W'(cur_cnt);
      wr_data      = s_ff;
      rd_en        = 1'b0;
      rd_pos       = '0;
      topz_in      = topz_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == bma_pkg::MODE_ALLOC) begin
                  size_in  = (req_request_size == '0) ? SZ_W'(1) : req_request_size;
                  p_in     = '0;
                  state_in = S_A_LOG;
               end else if (req_block_level > TOP) begin
                  res_ok_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  lvl_in   = req_block_level;
                  s_in     = req_block_start & ~((ADDR_W'(1) << req_block_level) - ADDR_W'(1));
                  state_in = S_F_CHK;
               end
            end
         end
         S_A_LOG: begin
            if (p_ff < TOP && (SZ_W'(1) << p_ff) < size_ff) begin
               p_in = p_ff + LVL_W'(1);
            end else if ((SZ_W'(1) << p_ff) >= size_ff) begin
               lvl_in   = p_ff;
               state_in = S_A_FIND;
            end else begin
               res_ok_in = 1'b0;
               state_in  = S_DONE;
            end
         end
         S_A_FIND: begin
            if (cur_cnt != '0) begin
               rd_en    = 1'b1;
               rd_pos   = '0;
               state_in = S_A_HEAD;
            end else if (lvl_ff == TOP) begin
               res_ok_in = 1'b0;
               state_in  = S_DONE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         S_A_HEAD: begin
            s_in     = rd_val;
            k_in     = '0;
            ret_in   = S_A_SPLIT;
            state_in = S_RM;
         end
         S_A_SPLIT: begin
            if (lvl_ff > p_ff) begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = S_A_APP;
            end else begin
               res_ok_in = 1'b1;
               res_s_in  = s_ff;
               res_l_in  = p_ff;
               state_in  = S_DONE;
            end
         end
         S_A_APP: begin
            if (cur_cnt < FULL) begin
               wr_en   = 1'b1;
               wr_data = s_ff + lvl_bit;
               cnt_inc = 1'b1;
            end
            state_in = S_A_SPLIT;
         end
         // Removal shifts the entries after position k down by one.
         S_RM: begin
            if (k_ff + CNT_W'(1) < cur_cnt) begin
               rd_en    = 1'b1;
               rd_pos   = ADDR_W'(k_ff + CNT_W'(1));
               state_in = S_RM_WR;
            end else begin
               cnt_dec  = 1'b1;
               state_in = ret_ff;
            end
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            wr_pos   = ADDR_W'(k_ff);
            wr_data  = rd_val;
            k_in     = k_ff + CNT_W'(1);
            state_in = S_RM;
         end
         S_F_CHK: begin
            k_in     = '0;
            state_in = (lvl_ff < TOP) ? S_F_SRCH : S_F_APP;
         end
         S_F_SRCH: begin
            if (k_ff < cur_cnt) begin
               rd_en    = 1'b1;
               rd_pos   = ADDR_W'(k_ff);
               state_in = S_F_CMP;
            end else begin
               state_in = S_F_APP;
            end
         end
         S_F_CMP: begin
            if (rd_val == (s_ff ^ lvl_bit)) begin
               ret_in   = S_F_MERGE;
               state_in = S_RM;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = S_F_SRCH;
            end
         end
         S_F_MERGE: begin
            s_in     = s_ff & ~lvl_bit;
            lvl_in   = lvl_ff + LVL_W'(1);
            state_in = S_F_CHK;
         end
         S_F_APP: begin
            if (cur_cnt < FULL) begin
               wr_en   = 1'b1;
               cnt_inc = 1'b1;
            end
            res_ok_in = 1'b1;
            res_s_in  = s_ff;
            res_l_in  = lvl_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_s_in     = res_ok_ff ? res_s_ff : '0;
               rsp_l_in     = res_ok_ff ? res_l_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // The top list's first entry reads as zero until the RAM holds a real value.
      if (wr_en && lvl_ff == TOP && wr_pos == '0) begin
         topz_in = 1'b0;
      end
   end

   assign virt_in = rd_en && topz_ff && lvl_ff == TOP && rd_pos == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         topz_ff      <= 1'b1;
         virt_ff      <= 1'b0;
         for (int i = 0; i < POOL_LEVELS; i++) begin
            cnt_ff[i] <= (i == POOL_LEVELS - 1) ? CNT_W'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         topz_ff      <= topz_in;
         virt_ff      <= virt_in;
         if (cnt_inc) begin
            cnt_ff[lvl_ff] <= cur_cnt + CNT_W'(1);
         end else if (cnt_dec) begin
            cnt_ff[lvl_ff] <= cur_cnt - CNT_W'(1);
         end
      end
      lvl_ff    <= lvl_in;
      p_ff      <= p_in;
      s_ff      <= s_in;
      k_ff      <= k_in;
      size_ff   <= size_in;
      res_ok_ff <= res_ok_in;
      res_s_ff  <= res_s_in;
      res_l_ff  <= res_l_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_s_ff  <= rsp_s_in;
      rsp_l_ff  <= rsp_l_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_granted_start = rsp_s_ff;
   assign rsp_granted_level = rsp_l_ff;

endmodule
